@@ src/bsm_pkg.sv @@
// shared types and constants for the bank switch mapper
// no dependencies; imported by bsm_core and the top level
package bsm_pkg;

  // operation codes of an input beat
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_TICK   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // write address decoding
  localparam logic [15:0] ADDR_LOW    = 16'h4120;
  localparam logic [15:0] MASK_PRG    = 16'hF100;
  localparam logic [15:0] PRG_HI_ADDR = 16'h4100;
  localparam logic [15:0] PRG_LO_ADDR = 16'h6100;
  localparam logic [15:0] MASK_REG    = 16'hE001;
  localparam logic [15:0] REG_COMMAND = 16'h8000;
  localparam logic [15:0] REG_DATA    = 16'h8001;
  localparam logic [15:0] REG_MIRROR  = 16'hA000;
  localparam logic [15:0] REG_LATCH   = 16'hC000;
  localparam logic [15:0] REG_RELOAD  = 16'hC001;
  localparam logic [15:0] REG_IRQ_OFF = 16'hE000;
  localparam logic [15:0] REG_IRQ_ON  = 16'hE001;

  // command codes: below CMD_FIRST_1K select a 2K bank, below CMD_END a 1K bank
  localparam logic [2:0] CMD_FIRST_1K = 3'd2;
  localparam logic [2:0] CMD_END      = 3'd6;

  // one input beat
  typedef struct packed {
    op_t         operation;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
    logic [12:0] ppu_address;
  } item_t;

  // one result beat
  typedef struct packed {
    logic       irq_pending;
    logic       mirroring;
    logic [3:0] prg_bank;
    logic [7:0] chr_bank;
  } result_t;

endpackage

@@ src/bsm_core.sv @@
// mapper register file, write decoder, scanline counter and pattern lookup
// depends on bsm_pkg
module bsm_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  bsm_pkg::item_t   item,
  output bsm_pkg::result_t result
);
  import bsm_pkg::*;

  logic [3:0] prg_bank_reg, prg_bank_reg_next;
  logic       mirror_reg, mirror_reg_next;
  logic [2:0] command_reg, command_reg_next;
  logic [6:0] chr_2k_regs [2];
  logic [6:0] chr_2k_regs_next [2];
  logic [7:0] chr_1k_regs [4];
  logic [7:0] chr_1k_regs_next [4];
  logic [7:0] irq_latch_reg, irq_latch_reg_next;
  logic [7:0] irq_counter, irq_counter_next;
  logic       irq_enable, irq_enable_next;
  logic       irq_flag, irq_flag_next;
  logic [2:0] slot;
  logic [2:0] cmd_1k;
  logic [7:0] chr;

  assign slot   = item.ppu_address[12:10];
  assign cmd_1k = command_reg - CMD_FIRST_1K;

  // next state for the beat being processed
  always_comb begin
    prg_bank_reg_next  = prg_bank_reg;
    mirror_reg_next    = mirror_reg;
    command_reg_next   = command_reg;
    chr_2k_regs_next   = chr_2k_regs;
    chr_1k_regs_next   = chr_1k_regs;
    irq_latch_reg_next = irq_latch_reg;
    irq_counter_next   = irq_counter;
    irq_enable_next    = irq_enable;
    irq_flag_next      = irq_flag;
    chr                = 8'd0;
    case (item.operation)
      OP_WRITE: begin
        if (item.cpu_address < ADDR_LOW) begin
          // low addresses are not decoded
        end else if ((item.cpu_address & MASK_PRG) == PRG_HI_ADDR) begin
          prg_bank_reg_next = item.write_data[7:4];
        end else if ((item.cpu_address & MASK_PRG) == PRG_LO_ADDR) begin
          prg_bank_reg_next = {2'b00, item.write_data[1:0]};
        end else begin
          unique case (item.cpu_address & MASK_REG)
            REG_COMMAND: command_reg_next = item.write_data[2:0];
            REG_DATA: begin
              if (command_reg < CMD_FIRST_1K) begin
                chr_2k_regs_next[command_reg[0]] = item.write_data[7:1];
              end else if (command_reg < CMD_END) begin
                chr_1k_regs_next[cmd_1k[1:0]] = item.write_data;
              end
            end
            REG_MIRROR:  mirror_reg_next = item.write_data[0];
            REG_LATCH:   irq_latch_reg_next = item.write_data;
            REG_RELOAD:  irq_counter_next = irq_latch_reg;
            REG_IRQ_OFF: begin
              irq_enable_next = 1'b0;
              irq_flag_next   = 1'b0;
            end
            REG_IRQ_ON:  irq_enable_next = 1'b1;
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        // decrement an armed counter, raise the line on reaching zero
        if (irq_enable && irq_counter != 8'd0) begin
          irq_counter_next = irq_counter - 8'd1;
          if (irq_counter == 8'd1) begin
            irq_flag_next = 1'b1;
          end
        end
      end
      OP_LOOKUP: begin
        if (!slot[2]) begin
          chr = {chr_2k_regs[slot[1]], slot[0]};
        end else begin
          chr = chr_1k_regs[slot[1:0]];
        end
      end
      default: ;
    endcase
  end

  // result reflects the state after this beat
  assign result.irq_pending = irq_flag_next;
  assign result.mirroring   = mirror_reg_next;
  assign result.prg_bank    = prg_bank_reg_next;
  assign result.chr_bank    = chr;

  // mapper state
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_reg  <= '0;
      mirror_reg    <= 1'b0;
      command_reg   <= '0;
      chr_2k_regs   <= '{default: '0};
      chr_1k_regs   <= '{default: '0};
      irq_latch_reg <= '0;
      irq_counter   <= '0;
      irq_enable    <= 1'b0;
      irq_flag      <= 1'b0;
    end else if (fire) begin
      prg_bank_reg  <= prg_bank_reg_next;
      mirror_reg    <= mirror_reg_next;
      command_reg   <= command_reg_next;
      chr_2k_regs   <= chr_2k_regs_next;
      chr_1k_regs   <= chr_1k_regs_next;
      irq_latch_reg <= irq_latch_reg_next;
      irq_counter   <= irq_counter_next;
      irq_enable    <= irq_enable_next;
      irq_flag      <= irq_flag_next;
    end
  end

`ifndef SYNTH
  // a pending interrupt is only ever held with the counter enabled
  a_flag_needs_enable: assert property (@(posedge clk) disable iff (rst)
    irq_flag |-> irq_enable)
    else $error("irq pending while counter disabled");

  // the interrupt only rises on a scanline tick
  a_flag_rise_on_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(irq_flag) |-> $past(fire && item.operation == OP_TICK))
    else $error("irq raised outside a tick");

  // an armed tick steps the counter down by exactly one
  a_tick_decrement: assert property (@(posedge clk) disable iff (rst)
    (fire && item.operation == OP_TICK && irq_enable && irq_counter != 8'd0)
      |=> irq_counter == $past(irq_counter) - 8'd1)
    else $error("counter did not decrement on tick");

  // no beat, no state change
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(irq_counter) && $stable(prg_bank_reg) && $stable(irq_flag))
    else $error("state changed without a beat");
`endif

endmodule

@@ src/bank_switch_mapper_with_line_irq.sv @@
// top level of the bank switch mapper with scanline interrupt
// depends on bsm_pkg and bsm_core
//
// usage
//   input channel: one beat per cpu write, scanline tick or pattern lookup,
//   carried on operation, cpu_address, write_data and ppu_address and
//   moved when in_valid is high and in_stall low.
//   output channel: one result beat per input beat, in order, on
//   irq_pending, mirroring, prg_bank and chr_bank, moved when out_valid is
//   high and out_stall low. chr_bank is zero unless the beat was a lookup.
//   path: input beat into the input register, then decode and state update
//   into the result register.
//   throughput: one beat per cycle while the receiver does not stall, set by
//   the single decode pass between the two registers.
//   reset: all mapper registers clear to zero, both registers empty.
//   receiver stall: the result is held; the input register keeps one more
//   beat, after which in_stall rises until the result is taken.
module bank_switch_mapper_with_line_irq (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   operation,
  input  logic [15:0]  cpu_address,
  input  logic [7:0]   write_data,
  input  logic [12:0]  ppu_address,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         irq_pending,
  output logic         mirroring,
  output logic [3:0]   prg_bank,
  output logic [7:0]   chr_bank
);
  import bsm_pkg::*;

  logic    in_reg_valid;
  item_t   in_reg;
  logic    advance;
  logic    accept;
  result_t result;
  result_t out_reg;

  // handshake control
  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (accept) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
    if (accept) begin
      in_reg.operation   <= op_t'(operation);
      in_reg.cpu_address <= cpu_address;
      in_reg.write_data  <= write_data;
      in_reg.ppu_address <= ppu_address;
    end
  end

  bsm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_reg),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_reg <= result;
    end
  end

  assign irq_pending = out_reg.irq_pending;
  assign mirroring   = out_reg.mirroring;
  assign prg_bank    = out_reg.prg_bank;
  assign chr_bank    = out_reg.chr_bank;

endmodule

@@ test/tb_bank_switch_mapper_with_line_irq.sv @@
// self-checking testbench for bank_switch_mapper_with_line_irq
// depends on bsm_pkg and the mapper rtl; the expected results come from a
// local model of the mapper registers and the scanline counter
module tb_bank_switch_mapper_with_line_irq;
  import bsm_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 2000;
  localparam int TAIL_CYCLES  = 10;
  localparam int MAX_REPORTS  = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = 2'd0;
  logic [15:0] cpu_address = 16'd0;
  logic [7:0]  write_data = 8'd0;
  logic [12:0] ppu_address = 13'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        irq_pending;
  logic        mirroring;
  logic [3:0]  prg_bank;
  logic [7:0]  chr_bank;

  // pending beats for the driver and results still owed by the mapper
  item_t   beat_q[$];
  result_t mapping_q[$];
  item_t   cur_beat;

  // idling of both sides for the current phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;

  int err_count = 0;

  // local copy of the mapper state
  logic [3:0] prg_q       = '0;
  logic       mirror_q    = 1'b0;
  logic [2:0] cmd_q       = '0;
  logic [6:0] chr2k_q [2] = '{default: '0};
  logic [7:0] chr1k_q [4] = '{default: '0};
  logic [7:0] latch_q     = '0;
  logic [7:0] count_q     = '0;
  logic       irq_en_q    = 1'b0;
  logic       irq_flag_q  = 1'b0;

  bank_switch_mapper_with_line_irq u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .cpu_address (cpu_address),
    .write_data  (write_data),
    .ppu_address (ppu_address),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .irq_pending (irq_pending),
    .mirroring   (mirroring),
    .prg_bank    (prg_bank),
    .chr_bank    (chr_bank)
  );

  always #2 clk = ~clk;

  // apply one beat to the local state and give the mapping it reports
  function automatic result_t map_beat(item_t b);
    result_t    r;
    logic [2:0] slot;
    logic [2:0] idx;
    r = '0;
    slot = b.ppu_address[12:10];
    case (b.operation)
      OP_WRITE: begin
        if (b.cpu_address < ADDR_LOW) begin
          // low addresses leave everything alone
        end else if ((b.cpu_address & MASK_PRG) == PRG_HI_ADDR) begin
          prg_q = b.write_data[7:4];
        end else if ((b.cpu_address & MASK_PRG) == PRG_LO_ADDR) begin
          prg_q = {2'b00, b.write_data[1:0]};
        end else begin
          case (b.cpu_address & MASK_REG)
            REG_COMMAND: cmd_q = b.write_data[2:0];
            REG_DATA: begin
              if (cmd_q < CMD_FIRST_1K) begin
                chr2k_q[cmd_q[0]] = b.write_data[7:1];
              end else if (cmd_q < CMD_END) begin
                idx = cmd_q - CMD_FIRST_1K;
                chr1k_q[idx[1:0]] = b.write_data;
              end
            end
            REG_MIRROR:  mirror_q = b.write_data[0];
            REG_LATCH:   latch_q = b.write_data;
            REG_RELOAD:  count_q = latch_q;
            REG_IRQ_OFF: begin
              irq_en_q = 1'b0;
              irq_flag_q = 1'b0;
            end
            REG_IRQ_ON:  irq_en_q = 1'b1;
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        if (irq_en_q && count_q != 8'd0) begin
          count_q = count_q - 8'd1;
          if (count_q == 8'd0) irq_flag_q = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (slot < 3'd2) r.chr_bank = {chr2k_q[0], b.ppu_address[10]};
        else if (slot < 3'd4) r.chr_bank = {chr2k_q[1], b.ppu_address[10]};
        else r.chr_bank = chr1k_q[slot[1:0]];
      end
      default: ;
    endcase
    r.irq_pending = irq_flag_q;
    r.mirroring = mirror_q;
    r.prg_bank = prg_q;
    return r;
  endfunction

  // driver: predict each accepted beat, then offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) mapping_q.push_back(map_beat(cur_beat));
      if (!in_valid || !in_stall) begin
        if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_beat = beat_q.pop_front();
          in_valid <= 1'b1;
          operation <= cur_beat.operation;
          cpu_address <= cur_beat.cpu_address;
          write_data <= cur_beat.write_data;
          ppu_address <= cur_beat.ppu_address;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off when asked for
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      hold_left <= 0;
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: compare each accepted result beat with the oldest mapping
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (mapping_q.size() == 0) begin
        if (err_count < MAX_REPORTS)
          $display("unexpected result beat irq=%0d mir=%0d prg=%0h chr=%0h",
                   irq_pending, mirroring, prg_bank, chr_bank);
        err_count = err_count + 1;
      end else begin
        want = mapping_q.pop_front();
        if (irq_pending !== want.irq_pending || mirroring !== want.mirroring ||
            prg_bank !== want.prg_bank || chr_bank !== want.chr_bank) begin
          if (err_count < MAX_REPORTS)
            $display("mismatch: expected irq=%0d mir=%0d prg=%0h chr=%0h",
                     want.irq_pending, want.mirroring, want.prg_bank, want.chr_bank,
                     ", got irq=%0d mir=%0d prg=%0h chr=%0h",
                     irq_pending, mirroring, prg_bank, chr_bank);
          err_count = err_count + 1;
        end
      end
    end
  end

  function automatic item_t mk(op_t op, logic [15:0] addr, logic [7:0] data,
                               logic [12:0] paddr);
    item_t b;
    b.operation = op;
    b.cpu_address = addr;
    b.write_data = data;
    b.ppu_address = paddr;
    return b;
  endfunction

  // beat with random content in every field
  function automatic item_t rand_beat(op_t op);
    return mk(op, 16'($urandom), 8'($urandom), 13'($urandom));
  endfunction

  // write to a decoded register, with the bits outside its mask random
  function automatic item_t reg_write(logic [15:0] base, logic [15:0] mask,
                                      logic [7:0] data);
    item_t b;
    b = rand_beat(OP_WRITE);
    b.cpu_address = base | (16'($urandom) & ~mask);
    b.write_data = data;
    return b;
  endfunction

  // random traffic, mostly register set-up, counter programming and ticks
  task automatic add_random(int n);
    int    cnt;
    int    r;
    item_t b;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // program the counter with a count, usually a short one, and enable it
        beat_q.push_back(reg_write(REG_LATCH, MASK_REG,
                         ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(6))));
        beat_q.push_back(reg_write(REG_RELOAD, MASK_REG, 8'($urandom)));
        beat_q.push_back(reg_write(REG_IRQ_ON, MASK_REG, 8'($urandom)));
        cnt = cnt + 3;
      end else if (r < 12) begin
        beat_q.push_back(reg_write(REG_IRQ_OFF, MASK_REG, 8'($urandom)));
        cnt = cnt + 1;
      end else if (r < 40) begin
        beat_q.push_back(rand_beat(OP_TICK));
        cnt = cnt + 1;
      end else if (r < 65) begin
        beat_q.push_back(rand_beat(OP_LOOKUP));
        cnt = cnt + 1;
      end else if (r < 77) begin
        // select a pattern bank and fill it
        beat_q.push_back(reg_write(REG_COMMAND, MASK_REG, 8'($urandom)));
        beat_q.push_back(reg_write(REG_DATA, MASK_REG, 8'($urandom)));
        cnt = cnt + 2;
      end else if (r < 88) begin
        case ($urandom_range(3))
          0: b = reg_write(PRG_HI_ADDR, MASK_PRG, 8'($urandom));
          1: b = reg_write(PRG_LO_ADDR, MASK_PRG, 8'($urandom));
          2: b = reg_write(REG_MIRROR, MASK_REG, 8'($urandom));
          default: b = reg_write(REG_LATCH, MASK_REG, 8'($urandom));
        endcase
        beat_q.push_back(b);
        cnt = cnt + 1;
      end else if (r < 96) begin
        // write anywhere, including the low and unmatched addresses
        beat_q.push_back(rand_beat(OP_WRITE));
        cnt = cnt + 1;
      end else begin
        beat_q.push_back(rand_beat(OP_NONE));
        cnt = cnt + 1;
      end
    end
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, int n);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    add_random(n);
    while (beat_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int drain;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed beats: state at reset, decode corners, bank map, counter
    beat_q.push_back(mk(OP_LOOKUP, 16'h0000, 8'h00, 13'h0000));
    beat_q.push_back(mk(OP_NONE, 16'hFFFF, 8'hFF, 13'h1FFF));
    beat_q.push_back(mk(OP_WRITE, 16'h411F, 8'hFF, 13'h0000));
    beat_q.push_back(mk(OP_WRITE, 16'h4120, 8'hF0, 13'h0000));
    beat_q.push_back(mk(OP_WRITE, 16'h6100, 8'hFF, 13'h0000));
    beat_q.push_back(mk(OP_WRITE, 16'hA000, 8'h01, 13'h0000));
    beat_q.push_back(mk(OP_WRITE, 16'hA001, 8'h00, 13'h0000));
    beat_q.push_back(mk(OP_WRITE, 16'h8000, 8'h00, 13'h0000));
    beat_q.push_back(mk(OP_WRITE, 16'h8001, 8'hFF, 13'h0000));
    beat_q.push_back(mk(OP_WRITE, 16'h8000, 8'h03, 13'h0000));
    beat_q.push_back(mk(OP_WRITE, 16'h8001, 8'hA5, 13'h0000));
    beat_q.push_back(mk(OP_WRITE, 16'h8000, 8'h06, 13'h0000));
    beat_q.push_back(mk(OP_WRITE, 16'h8001, 8'h5A, 13'h0000));
    beat_q.push_back(mk(OP_LOOKUP, 16'h0000, 8'h00, 13'h07FF));
    beat_q.push_back(mk(OP_LOOKUP, 16'h0000, 8'h00, 13'h1400));
    beat_q.push_back(mk(OP_WRITE, 16'hC000, 8'h02, 13'h0000));
    beat_q.push_back(mk(OP_WRITE, 16'hC001, 8'h00, 13'h0000));
    // tick while disabled holds the count
    beat_q.push_back(mk(OP_TICK, 16'h0000, 8'h00, 13'h0000));
    beat_q.push_back(mk(OP_WRITE, 16'hFFFF, 8'hFF, 13'h0000));
    beat_q.push_back(mk(OP_TICK, 16'h0000, 8'h00, 13'h0000));
    beat_q.push_back(mk(OP_TICK, 16'h0000, 8'h00, 13'h0000));
    // tick at zero holds and the line stays up until acknowledged
    beat_q.push_back(mk(OP_TICK, 16'hFFFF, 8'hFF, 13'h1FFF));
    beat_q.push_back(mk(OP_WRITE, 16'hE000, 8'h00, 13'h0000));
    while (beat_q.size() != 0) @(posedge clk);

    run_phase(0, 0, 400);
    run_phase(45, 0, 400);
    run_phase(0, 45, 400);
    run_phase(14, 14, 400);

    // long receiver hold-off while the sender keeps offering
    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    add_random(150);
    while (beat_q.size() != 0) @(posedge clk);

    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (in_valid) @(posedge clk);
    drain = 0;
    while (mapping_q.size() != 0 && drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain = drain + 1;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mapping_q.size() != 0) begin
      if (err_count < MAX_REPORTS)
        $display("%0d result beats never arrived", mapping_q.size());
      err_count = err_count + 1;
    end

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ bank_switch_mapper_with_line_irq.f @@
src/bsm_pkg.sv
src/bsm_core.sv
src/bank_switch_mapper_with_line_irq.sv
test/tb_bank_switch_mapper_with_line_irq.sv
